/* hw/rtl/assert_macros.svh */
// Assertion macros used by the converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/sbda_pkg.sv */
// Types and constants for the signed binary to decimal ASCII converter.
`default_nettype none
package sbda_pkg;
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } sbda_state_type;

   localparam int unsigned CHAR_W        = 6;
   localparam int unsigned DIGIT_W       = 4;
   localparam int unsigned BITS_PER_STEP = 4;

   localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CODE_NINE  = 6'd57;
endpackage
`default_nettype wire

/* hw/rtl/signed_binary_to_decimal_ascii_core.sv */
// '-' (negative inputs) appears the cycle after accept; the digits follow once the shared
// shift-add-3 unit has converted the magnitude, BITS_PER_STEP bits per conversion step.
// Digit emission walks all NUM_DIGITS BCD positions, one per cycle, skipping leading zeros.
// A new value is accepted only while idle; busy stays high until the item's last digit is emitted.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset is synchronous, active high, returns to idle with no strobe pending.
`default_nettype none
`include "assert_macros.svh"
module signed_binary_to_decimal_ascii_core
   import sbda_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic signed [63:0]       req_value,
   output      logic                     rsp_valid,
   output      logic [CHAR_W-1:0]        rsp_char_code,
   output      logic                     rsp_last
);
   localparam int unsigned STEPS      = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int unsigned MAG_W      = STEPS * BITS_PER_STEP;
   localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int unsigned STEP_CNT_W = $clog2(STEPS);
   localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);
   localparam logic [STEP_CNT_W-1:0] LAST_STEP  = STEP_CNT_W'(STEPS - 1);
   localparam logic [DIG_CNT_W-1:0]  LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

   sbda_state_type          state_ff, state_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0]   step_ff, step_in;
   logic [DIG_CNT_W-1:0]    dig_ff, dig_in;
   logic                    started_ff, started_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0]  val;
   logic                    neg;
   logic [VALUE_WIDTH-1:0]  mag_abs;
   logic [BCD_W-1:0]        bcd_step;
   logic [MAG_W-1:0]        mag_step;
   logic [DIGIT_W-1:0]      top_digit;

   assign val     = req_value[VALUE_WIDTH-1:0];
   assign neg     = val[VALUE_WIDTH-1];
   assign mag_abs = neg ? (~val + VALUE_WIDTH'(1)) : val;

   // Shared unit: four shift-add-3 passes over the BCD register.
   always_comb begin
      logic [BCD_W-1:0] b;
      logic [MAG_W-1:0] m;
      b = bcd_ff;
      m = mag_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
               b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], m[MAG_W-1]};
         m = {m[MAG_W-2:0], 1'b0};
      end
      bcd_step = b;
      mag_step = m;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      dig_in       = dig_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mag_in       = MAG_W'(mag_abs);
               bcd_in       = '0;
               step_in      = '0;
               state_in     = ST_CONV;
               // emit the sign right away; it is never the final word
               rsp_valid_in = neg;
               rsp_char_in  = CODE_MINUS;
            end
         end
         ST_CONV: begin
            mag_in  = mag_step;
            bcd_in  = bcd_step;
            step_in = step_ff + STEP_CNT_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in   = ST_EMIT;
               dig_in     = '0;
               started_in = 1'b0;
            end
         end
         ST_EMIT: begin
            bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_in = dig_ff + DIG_CNT_W'(1);
            // drop leading zeros, but always emit the ones digit
            if (top_digit != '0 || started_ff || dig_ff == LAST_DIGIT) begin
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = CODE_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
               rsp_last_in  = (dig_ff == LAST_DIGIT);
            end
            if (dig_ff == LAST_DIGIT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         started_ff   <= 1'b0;
         step_ff      <= '0;
         dig_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         started_ff   <= started_in;
         step_ff      <= step_in;
         dig_ff       <= dig_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   `ASSERT_IMPLY(a_last_ends_item, clock, reset, rsp_valid && rsp_last, !busy)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_char_range, clock, reset, rsp_valid, rsp_char_code == CODE_MINUS || (rsp_char_code >= CODE_ZERO && rsp_char_code <= CODE_NINE))
   `ASSERT_IMPLY(a_minus_not_last, clock, reset, rsp_valid && rsp_char_code == CODE_MINUS, !rsp_last)
endmodule
`default_nettype wire
